@@ hdl/spd_pkg.sv @@
package spd_pkg;

    // header layout and framing constants
    localparam logic [15:0] PREAMBLE     = 16'hABCD;
    localparam logic [15:0] RSV_WORD_1   = 16'hF1F1;
    localparam logic [15:0] RSV_WORD_2   = 16'hF2F2;
    localparam logic [15:0] RSV_WORD_3   = 16'hF3F3;
    localparam logic [7:0]  TYPE_ANALOG  = 8'h00;
    localparam logic [7:0]  TYPE_DIGITAL = 8'hFF;
    localparam int          HDR_BYTES    = 16;
    localparam int          WIN_DEPTH    = 15;
    localparam int          OVERHEAD     = 18;
    localparam int          MIN_TOTAL    = 20;

    // voltage conversion
    localparam logic [15:0] FULL_SCALE_RESET = 16'd3300;
    localparam int          MV_DIVISOR       = 255;

    // register map (index taken from paddr[2])
    localparam logic [0:0] REG_FULL_SCALE = 1'b0;

    // packet queue between front and back
    localparam int SLOTS  = 2;
    localparam int SLOT_W = 1;

    // parameter defaults
    localparam int DEF_MAX_SAMPLE_BYTES = 16;
    localparam int DEF_CHANNELS         = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  src_kind;
        logic [7:0]  src_chan;
        logic [31:0] timestamp;
        logic [2:0]  channel_index;
        logic        time_index;
        logic [7:0]  raw_code;
        logic [15:0] millivolts;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  ptype;
        logic [7:0]  pchan;
        logic [31:0] ptime;
    } t_pkt_meta;

    // front to queue control
    typedef struct packed {
        logic hdr_we;
        logic sample_we;
        logic push;
    } t_fq_ctrl;

    // back to queue control
    typedef struct packed {
        logic rd_en;
        logic pop;
    } t_bq_ctrl;

endpackage

@@ hdl/spd_front.sv @@
module spd_front import spd_pkg::*; #(
    parameter int MAX_SAMPLE_BYTES = DEF_MAX_SAMPLE_BYTES
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  t_in_item                                 i_in,
    input  logic                                     i_q_full,
    output t_fq_ctrl                                 o_ctrl,
    output logic [$clog2(MAX_SAMPLE_BYTES)-1:0]      o_sample_idx,
    output logic [7:0]                               o_sample_data,
    output t_pkt_meta                                o_meta,
    output logic [$clog2(MAX_SAMPLE_BYTES+1)-1:0]    o_count
);

    localparam int K_W   = $clog2(MAX_SAMPLE_BYTES);
    localparam int N_W   = $clog2(MAX_SAMPLE_BYTES + 1);
    localparam int TOT_W = $clog2(OVERHEAD + MAX_SAMPLE_BYTES + 1);

    localparam logic PH_HUNT    = 1'b0;
    localparam logic PH_COLLECT = 1'b1;

    localparam logic [3:0] FILL_FULL = 4'(WIN_DEPTH);

    logic             r_phase, n_phase;
    logic [3:0]       r_fill, n_fill;
    logic [TOT_W-1:0] r_total, n_total;
    logic [TOT_W-1:0] r_seen, n_seen;
    logic [7:0]       r_win [WIN_DEPTH];

    logic             accept;
    logic             hdr_ok;
    logic [15:0]      len;
    logic [TOT_W:0]   pos_ext;
    logic [TOT_W-1:0] seen_inc;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // candidate header: window bytes 0..14 plus the new byte
    assign len = {r_win[8], r_win[9]};
    assign hdr_ok = ({r_win[0], r_win[1]} == PREAMBLE)
        && ((r_win[2] == TYPE_ANALOG) || (r_win[2] == TYPE_DIGITAL))
        && (len >= 16'(MIN_TOTAL))
        && (len <= 16'(OVERHEAD + MAX_SAMPLE_BYTES))
        && ({r_win[10], r_win[11]} == RSV_WORD_1)
        && ({r_win[12], r_win[13]} == RSV_WORD_2)
        && ({r_win[14], i_in.data_byte} == RSV_WORD_3);

    assign o_meta.ptype = r_win[2];
    assign o_meta.pchan = r_win[3];
    assign o_meta.ptime = {r_win[6], r_win[7], r_win[4], r_win[5]};
    assign o_count      = N_W'(len - 16'(OVERHEAD));

    // sample position within the packet
    assign pos_ext       = {1'b0, r_seen} - (TOT_W + 1)'(HDR_BYTES);
    assign o_sample_idx  = pos_ext[K_W-1:0];
    assign o_sample_data = i_in.data_byte;
    assign seen_inc      = r_seen + TOT_W'(1);

    // hunt / collect control
    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_total = r_total;
        n_seen  = r_seen;
        o_ctrl  = '0;
        unique case (r_phase)
            PH_HUNT: begin
                if (accept) begin
                    if (r_fill != FILL_FULL) begin
                        n_fill = r_fill + 4'd1;
                    end else if (hdr_ok) begin
                        o_ctrl.hdr_we = 1'b1;
                        n_total = TOT_W'(len);
                        n_seen  = TOT_W'(HDR_BYTES);
                        n_fill  = 4'd0;
                        n_phase = PH_COLLECT;
                    end
                end
            end
            PH_COLLECT: begin
                if (accept) begin
                    o_ctrl.sample_we = ({1'b0, r_seen} + (TOT_W + 1)'(2)) < {1'b0, r_total};
                    n_seen = seen_inc;
                    if (seen_inc >= r_total) begin
                        o_ctrl.push = 1'b1;
                        n_phase = PH_HUNT;
                        n_fill  = 4'd0;
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
                n_fill  = 4'd0;
            end
        endcase
        // end of buffer drops any unfinished packet and the window
        if (accept && i_in.buffer_last) begin
            n_phase = PH_HUNT;
            n_fill  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_fill  <= 4'd0;
            r_total <= '0;
            r_seen  <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_seen  <= n_seen;
        end
    end

    // sliding window, shifted on every hunting byte
    always_ff @(posedge i_clk) begin
        if (accept && (r_phase == PH_HUNT)) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_DEPTH-1] <= i_in.data_byte;
        end
    end

endmodule

@@ hdl/spd_queue.sv @@
module spd_queue import spd_pkg::*; #(
    parameter int MAX_SAMPLE_BYTES = DEF_MAX_SAMPLE_BYTES
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // front side
    input  t_fq_ctrl                                 i_fctrl,
    input  logic [$clog2(MAX_SAMPLE_BYTES)-1:0]      i_sample_idx,
    input  logic [7:0]                               i_sample_data,
    input  t_pkt_meta                                i_meta,
    input  logic [$clog2(MAX_SAMPLE_BYTES+1)-1:0]    i_count,
    output logic                                     o_full,
    // back side
    input  t_bq_ctrl                                 i_bctrl,
    input  logic [$clog2(MAX_SAMPLE_BYTES)-1:0]      i_rd_idx,
    output logic                                     o_not_empty,
    output t_pkt_meta                                o_meta,
    output logic [$clog2(MAX_SAMPLE_BYTES+1)-1:0]    o_count,
    output logic [7:0]                               o_rd_data
);

    localparam int K_W       = $clog2(MAX_SAMPLE_BYTES);
    localparam int N_W       = $clog2(MAX_SAMPLE_BYTES + 1);
    localparam int MEM_DEPTH = SLOTS << K_W;

    logic [SLOT_W:0]   r_used;
    logic [SLOT_W-1:0] r_wp, r_rp;

    logic [7:0]     r_mem   [MEM_DEPTH];
    t_pkt_meta      r_meta  [SLOTS];
    logic [N_W-1:0] r_count [SLOTS];
    logic [7:0]     r_rd_data;

    assign o_full      = (r_used == (SLOT_W + 1)'(SLOTS));
    assign o_not_empty = (r_used != '0);
    assign o_meta      = r_meta[r_rp];
    assign o_count     = r_count[r_rp];
    assign o_rd_data   = r_rd_data;

    // slot pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
        end else begin
            if (i_fctrl.push) begin
                r_wp <= r_wp + SLOT_W'(1);
            end
            if (i_bctrl.pop) begin
                r_rp <= r_rp + SLOT_W'(1);
            end
            if (i_fctrl.push && !i_bctrl.pop) begin
                r_used <= r_used + (SLOT_W + 1)'(1);
            end else if (!i_fctrl.push && i_bctrl.pop) begin
                r_used <= r_used - (SLOT_W + 1)'(1);
            end
        end
    end

    // per-packet header fields
    always_ff @(posedge i_clk) begin
        if (i_fctrl.hdr_we) begin
            r_meta[r_wp]  <= i_meta;
            r_count[r_wp] <= i_count;
        end
    end

    // sample memory, one bank per slot
    always_ff @(posedge i_clk) begin
        if (i_fctrl.sample_we) begin
            r_mem[{r_wp, i_sample_idx}] <= i_sample_data;
        end
        if (i_bctrl.rd_en) begin
            r_rd_data <= r_mem[{r_rp, i_rd_idx}];
        end
    end

endmodule

@@ hdl/spd_back.sv @@
module spd_back import spd_pkg::*; #(
    parameter int MAX_SAMPLE_BYTES = DEF_MAX_SAMPLE_BYTES,
    parameter int CHANNELS         = DEF_CHANNELS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [15:0]                              i_full_scale_mv,
    input  logic                                     i_q_not_empty,
    input  t_pkt_meta                                i_meta,
    input  logic [$clog2(MAX_SAMPLE_BYTES+1)-1:0]    i_count,
    input  logic [7:0]                               i_rd_data,
    output t_bq_ctrl                                 o_bctrl,
    output logic [$clog2(MAX_SAMPLE_BYTES)-1:0]      o_rd_idx,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output t_out_item                                o_out
);

    localparam int K_W  = $clog2(MAX_SAMPLE_BYTES);
    localparam int N_W  = $clog2(MAX_SAMPLE_BYTES + 1);
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    logic [K_W-1:0]  r_k;
    logic [CH_W-1:0] r_ch;

    logic            r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_out_item       r_s1, r_s2, r_s3, r_out;
    logic [23:0]     r_s2_prod, r_s3_prod;
    logic [15:0]     r_s3_quot;

    logic            adv, issue, k_last;
    logic [CH_W+2:0] ch_ext;
    t_out_item       s1_item;
    t_out_item       s2_item;
    t_out_item       out_item;
    logic [23:0]     prod;
    logic [24:0]     est_sum;
    logic [24:0]     rem;
    logic            bump;

    // whole pipeline moves when the output register can take a new result
    assign adv    = !r_out_valid || i_out_ready;
    assign issue  = adv && i_q_not_empty;
    assign k_last = (N_W'(r_k) + N_W'(1)) == i_count;

    assign o_bctrl.rd_en = issue;
    assign o_bctrl.pop   = issue && k_last;
    assign o_rd_idx      = r_k;

    assign ch_ext = {3'b000, r_ch};

    // result fields known at issue time
    always_comb begin
        s1_item               = '0;
        s1_item.src_kind      = i_meta.ptype;
        s1_item.src_chan      = i_meta.pchan;
        s1_item.timestamp     = i_meta.ptime;
        s1_item.channel_index = ch_ext[2:0];
        s1_item.time_index    = r_k[0];
        s1_item.last          = k_last;
    end

    // sample and channel counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_ch <= '0;
        end else if (issue) begin
            if (k_last) begin
                r_k  <= '0;
                r_ch <= '0;
            end else begin
                r_k <= r_k + K_W'(1);
                if (r_k[0]) begin
                    r_ch <= (r_ch == CH_LAST) ? '0 : r_ch + CH_W'(1);
                end
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= issue;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // scale: raw code times full scale
    assign prod = 24'(i_rd_data) * 24'(i_full_scale_mv);

    // divide by 255: estimate from p/256 series, low by at most one
    assign est_sum = 25'(r_s2_prod) + 25'(r_s2_prod >> 8) + 25'(r_s2_prod >> 16);

    // remainder check corrects the estimate
    assign rem  = 25'(r_s3_prod) + 25'(r_s3_quot) - (25'(r_s3_quot) << 8);
    assign bump = rem >= 25'(MV_DIVISOR);

    // raw code joins the item once the memory read returns
    always_comb begin
        s2_item          = r_s1;
        s2_item.raw_code = i_rd_data;
    end

    // corrected quotient joins the item at the output register
    always_comb begin
        out_item            = r_s3;
        out_item.millivolts = r_s3_quot + 16'(bump);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1 <= s1_item;

            r_s2      <= s2_item;
            r_s2_prod <= prod;

            r_s3      <= r_s2;
            r_s3_prod <= r_s2_prod;
            r_s3_quot <= est_sum[23:8];

            r_out <= out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hdl/sample_packet_deframer.sv @@
// Sample packet deframer.
// Input channel: one stream byte per request (i_in.data_byte), with
// i_in.buffer_last set on the last byte of a transfer buffer. Bytes are
// scanned for a 16-byte header (preamble ABCD, type 00 or FF, length 20 to
// 18 plus MAX_SAMPLE_BYTES, reserved words F1F1 F2F2 F3F3); sample bytes
// after it are stored and the two checksum bytes are skipped.
// Output channel: one request per sample byte once the packet's last byte
// is in, carrying header fields, channel/time index, raw code and
// millivolts = floor(raw * full_scale_mv / 255); last marks the final one.
// Config: full_scale_mv at byte address 0 over the APB port, reset 3300.
// Throughput: one input byte per cycle. The front takes a byte every cycle
// while the two-slot packet queue has a free slot; the back issues one
// result per cycle out of the sample memory read port unless the receiver
// stalls. Path: a packet's first result passes the memory read, multiply,
// divide estimate and correction registers after its final byte is accepted.
// Reset: the window is emptied, the queue is cleared, hunting restarts.
// When the receiver stalls the back pipeline holds; the front keeps taking
// bytes until both queue slots hold finished packets, then deasserts ready.
module sample_packet_deframer import spd_pkg::*; #(
    parameter int MAX_SAMPLE_BYTES = DEF_MAX_SAMPLE_BYTES,
    parameter int CHANNELS         = DEF_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    // result stream
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int K_W = $clog2(MAX_SAMPLE_BYTES);
    localparam int N_W = $clog2(MAX_SAMPLE_BYTES + 1);

    logic [15:0] r_full_scale_mv;

    t_fq_ctrl       fctrl;
    t_bq_ctrl       bctrl;
    logic [K_W-1:0] sample_idx, rd_idx;
    logic [7:0]     sample_data, rd_data;
    t_pkt_meta      f_meta, b_meta;
    logic [N_W-1:0] f_count, b_count;
    logic           q_full, q_not_empty;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale_mv <= FULL_SCALE_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_FULL_SCALE)) begin
            r_full_scale_mv <= pwdata[15:0];
        end
    end
    assign prdata = (paddr[2] == REG_FULL_SCALE) ? {16'd0, r_full_scale_mv} : 32'd0;

    spd_front #(
        .MAX_SAMPLE_BYTES(MAX_SAMPLE_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .i_q_full      (q_full),
        .o_ctrl        (fctrl),
        .o_sample_idx  (sample_idx),
        .o_sample_data (sample_data),
        .o_meta        (f_meta),
        .o_count       (f_count)
    );

    spd_queue #(
        .MAX_SAMPLE_BYTES(MAX_SAMPLE_BYTES)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fctrl       (fctrl),
        .i_sample_idx  (sample_idx),
        .i_sample_data (sample_data),
        .i_meta        (f_meta),
        .i_count       (f_count),
        .o_full        (q_full),
        .i_bctrl       (bctrl),
        .i_rd_idx      (rd_idx),
        .o_not_empty   (q_not_empty),
        .o_meta        (b_meta),
        .o_count       (b_count),
        .o_rd_data     (rd_data)
    );

    spd_back #(
        .MAX_SAMPLE_BYTES(MAX_SAMPLE_BYTES),
        .CHANNELS        (CHANNELS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_full_scale_mv (r_full_scale_mv),
        .i_q_not_empty   (q_not_empty),
        .i_meta          (b_meta),
        .i_count         (b_count),
        .i_rd_data       (rd_data),
        .o_bctrl         (bctrl),
        .o_rd_idx        (rd_idx),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out           (o_out)
    );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import spd_pkg::*;

    localparam int MAX_SAMPLES     = DEF_MAX_SAMPLE_BYTES;
    localparam int CHAN_COUNT      = DEF_CHANNELS;
    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int RX_STALL_CYCLES = 300;
    localparam int WHOLE_FRAME     = 1 << 20;

    typedef enum logic {SCAN_HUNT, SCAN_COLLECT} t_scan_phase;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    sample_packet_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // deframer prediction state
    logic [7:0]  win_bytes [WIN_DEPTH];
    int unsigned win_fill;
    t_scan_phase scan_phase;
    logic [7:0]  pkt_type;
    logic [7:0]  pkt_chan;
    logic [31:0] pkt_time;
    int unsigned pkt_total;
    int unsigned pkt_seen;
    logic [7:0]  sample_mem [MAX_SAMPLES];
    logic [15:0] full_scale;
    t_out_item   pending_samples [$];

    // stimulus state
    logic [7:0]  frame_buf [$];
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned mismatch_count = 0;
    logic        rx_hold = 1'b0;
    event        rx_stall_go;
    t_out_item   want;

    function automatic void flag_mismatch(string what);
        if (mismatch_count < 10)
            $display("MISMATCH: %s", what);
        mismatch_count++;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < WIN_DEPTH; i++)
            win_bytes[i] = 8'h00;
        win_fill   = 0;
        scan_phase = SCAN_HUNT;
        pkt_type   = 8'h00;
        pkt_chan   = 8'h00;
        pkt_time   = 32'h0;
        pkt_total  = 0;
        pkt_seen   = 0;
        full_scale = FULL_SCALE_RESET;
    endfunction

    function automatic void restart_hunt();
        scan_phase = SCAN_HUNT;
        win_fill   = 0;
        pkt_seen   = 0;
    endfunction

    // one expected result per stored sample byte
    function automatic void queue_packet_samples();
        int unsigned n;
        t_out_item   r;
        n = pkt_total - OVERHEAD;
        for (int unsigned k = 0; k < n && k < MAX_SAMPLES; k++) begin
            r.src_kind      = pkt_type;
            r.src_chan      = pkt_chan;
            r.timestamp     = pkt_time;
            r.channel_index = 3'((k >> 1) % CHAN_COUNT);
            r.time_index    = 1'(k & 1);
            r.raw_code      = sample_mem[k];
            r.millivolts    = 16'((32'(sample_mem[k]) * 32'(full_scale)) / MV_DIVISOR);
            r.last          = (k + 1 == n);
            pending_samples.push_back(r);
        end
    endfunction

    // advance the deframer by one stream byte
    function automatic void deframe_byte(logic [7:0] b, logic bl);
        logic [7:0]  hdr [HDR_BYTES];
        int unsigned len;
        if (scan_phase == SCAN_COLLECT) begin
            if (pkt_seen >= HDR_BYTES && pkt_seen - HDR_BYTES < pkt_total - OVERHEAD &&
                pkt_seen - HDR_BYTES < MAX_SAMPLES)
                sample_mem[pkt_seen - HDR_BYTES] = b;
            pkt_seen++;
            if (pkt_seen >= pkt_total) begin
                queue_packet_samples();
                restart_hunt();
            end
        end else if (win_fill < WIN_DEPTH) begin
            win_bytes[win_fill] = b;
            win_fill++;
        end else begin
            for (int i = 0; i < WIN_DEPTH; i++)
                hdr[i] = win_bytes[i];
            hdr[WIN_DEPTH] = b;
            len = 32'({hdr[8], hdr[9]});
            if ({hdr[0], hdr[1]} == PREAMBLE &&
                (hdr[2] == TYPE_ANALOG || hdr[2] == TYPE_DIGITAL) &&
                len >= MIN_TOTAL && len <= OVERHEAD + MAX_SAMPLES &&
                {hdr[10], hdr[11]} == RSV_WORD_1 &&
                {hdr[12], hdr[13]} == RSV_WORD_2 &&
                {hdr[14], hdr[15]} == RSV_WORD_3) begin
                pkt_type   = hdr[2];
                pkt_chan   = hdr[3];
                pkt_time   = {hdr[6], hdr[7], hdr[4], hdr[5]};
                pkt_total  = len;
                pkt_seen   = HDR_BYTES;
                win_fill   = 0;
                scan_phase = SCAN_COLLECT;
            end else begin
                for (int i = 0; i < WIN_DEPTH - 1; i++)
                    win_bytes[i] = win_bytes[i + 1];
                win_bytes[WIN_DEPTH - 1] = b;
            end
        end
        if (bl)
            restart_hunt();
    endfunction

    // frame assembly
    function automatic void push_random(int n);
        for (int i = 0; i < n; i++)
            frame_buf.push_back(8'($urandom));
    endfunction

    function automatic void build_frame(logic [7:0] ptype, logic [7:0] chan,
                                        logic [31:0] stamp, int total);
        logic [15:0] len;
        len = 16'(total);
        frame_buf.push_back(PREAMBLE[15:8]);
        frame_buf.push_back(PREAMBLE[7:0]);
        frame_buf.push_back(ptype);
        frame_buf.push_back(chan);
        frame_buf.push_back(stamp[15:8]);
        frame_buf.push_back(stamp[7:0]);
        frame_buf.push_back(stamp[31:24]);
        frame_buf.push_back(stamp[23:16]);
        frame_buf.push_back(len[15:8]);
        frame_buf.push_back(len[7:0]);
        frame_buf.push_back(RSV_WORD_1[15:8]);
        frame_buf.push_back(RSV_WORD_1[7:0]);
        frame_buf.push_back(RSV_WORD_2[15:8]);
        frame_buf.push_back(RSV_WORD_2[7:0]);
        frame_buf.push_back(RSV_WORD_3[15:8]);
        frame_buf.push_back(RSV_WORD_3[7:0]);
        push_random(total - HDR_BYTES);
    endfunction

    function automatic void build_random_frame();
        build_frame($urandom_range(1) ? TYPE_DIGITAL : TYPE_ANALOG, 8'($urandom),
                    $urandom, $urandom_range(MIN_TOTAL, OVERHEAD + MAX_SAMPLES));
    endfunction

    // one input request, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic bl);
        t_in_item req;
        req.data_byte   = b;
        req.buffer_last = bl;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        deframe_byte(b, bl);
        bytes_sent++;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // send up to count bytes of the frame buffer, optionally ending the transfer buffer
    task automatic send_frame(input int count, input bit mark_end);
        int n;
        n = (count < frame_buf.size()) ? count : frame_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(frame_buf[i], mark_end && (i == n - 1));
        frame_buf.delete();
    endtask

    // sender stops until all expected results are in and the block is quiet
    task automatic wait_drain();
        int unsigned waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_samples.size() != 0) begin
            flag_mismatch($sformatf("%0d sample results never arrived",
                                    pending_samples.size()));
            pending_samples.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb access, setup then access phase
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_FULL_SCALE, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_full_scale(input logic [15:0] value);
        logic [31:0] rd;
        apb_access(1'b1, {16'h0, value}, rd);
        full_scale = value;
        apb_access(1'b0, 32'h0, rd);
        if (rd[15:0] !== value)
            flag_mismatch($sformatf("full_scale_mv readback: expected %h got %h",
                                    value, rd[15:0]));
    endtask

    // one short packet carrying both code extremes at a given full scale
    task automatic scale_check(input logic [15:0] value);
        write_full_scale(value);
        build_frame(TYPE_ANALOG, 8'($urandom), $urandom, MIN_TOTAL);
        frame_buf[HDR_BYTES]     = 8'h00;
        frame_buf[HDR_BYTES + 1] = 8'hFF;
        send_frame(WHOLE_FRAME, 1'b0);
        wait_drain();
    endtask

    task automatic test_full_scale();
        logic [31:0] rd;
        apb_access(1'b0, 32'h0, rd);
        if (rd[15:0] !== FULL_SCALE_RESET)
            flag_mismatch($sformatf("full_scale_mv after reset: expected %h got %h",
                                    FULL_SCALE_RESET, rd[15:0]));
        scale_check(16'hFFFF);
        scale_check(16'd0);
        write_full_scale(FULL_SCALE_RESET);
    endtask

    task automatic test_framing();
        // oversized length header is skipped
        build_frame(TYPE_DIGITAL, 8'h56, $urandom, OVERHEAD + MAX_SAMPLES + 1);
        send_frame(HDR_BYTES, 1'b0);
        // end of buffer inside the samples drops the packet
        build_frame(TYPE_ANALOG, 8'h5A, $urandom, MIN_TOTAL + 6);
        send_frame(HDR_BYTES + 3, 1'b1);
        // end of buffer on the completing byte still emits
        build_frame(TYPE_DIGITAL, 8'h22, $urandom, MIN_TOTAL);
        send_frame(WHOLE_FRAME, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input logic [15:0] scale, input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned pick;
        write_full_scale(scale);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                // well-formed packet
                build_random_frame();
                send_frame(WHOLE_FRAME, 1'b0);
            end else if (pick < 78) begin
                // packet cut short by end of buffer
                build_random_frame();
                send_frame($urandom_range(1, frame_buf.size() - 1), 1'b1);
            end else if (pick < 86) begin
                // one flipped header bit
                build_random_frame();
                frame_buf[$urandom_range(HDR_BYTES - 1)] ^= 8'(1 << $urandom_range(7));
                send_frame(WHOLE_FRAME, 1'b0);
            end else begin
                // line noise
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    send_byte(8'($urandom), $urandom_range(9) == 0);
            end
        end
        // close the transfer buffer so the next register write sees an idle block
        send_byte(8'($urandom), 1'b1);
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        -> rx_stall_go;
        // longest digital packet, channel and timestamp fields all ones
        build_frame(TYPE_DIGITAL, 8'hFF, 32'hFFFF_FFFF, OVERHEAD + MAX_SAMPLES);
        send_frame(WHOLE_FRAME, 1'b0);
        build_frame(TYPE_ANALOG, 8'($urandom), $urandom, MIN_TOTAL);
        send_frame(WHOLE_FRAME, 1'b0);
        // both slots hold packets now, so these bytes wait for the receiver
        push_random(2);
        send_frame(WHOLE_FRAME, 1'b1);
        wait_drain();
    endtask

    // result side readiness
    always @(posedge i_clk) begin
        if (rx_hold)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off
    always begin
        @(rx_stall_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (RX_STALL_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // compare each result request with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_samples.size() == 0) begin
                flag_mismatch($sformatf("unexpected sample result %h", o_out));
            end else begin
                want = pending_samples.pop_front();
                if (o_out.src_kind      !== want.src_kind      ||
                    o_out.src_chan      !== want.src_chan      ||
                    o_out.timestamp     !== want.timestamp     ||
                    o_out.channel_index !== want.channel_index ||
                    o_out.time_index    !== want.time_index    ||
                    o_out.raw_code      !== want.raw_code      ||
                    o_out.millivolts    !== want.millivolts    ||
                    o_out.last          !== want.last)
                    flag_mismatch($sformatf(
                        {"sample result: expected type %h ch %h ts %h idx %0d t %0d raw %h ",
                         "mv %0d last %0d, got type %h ch %h ts %h idx %0d t %0d raw %h ",
                         "mv %0d last %0d"},
                        want.src_kind, want.src_chan, want.timestamp,
                        want.channel_index, want.time_index, want.raw_code,
                        want.millivolts, want.last,
                        o_out.src_kind, o_out.src_chan, o_out.timestamp,
                        o_out.channel_index, o_out.time_index, o_out.raw_code,
                        o_out.millivolts, o_out.last));
            end
        end
    end

    initial begin
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_scale();
        test_framing();
        test_random_traffic(17, 76, 16'($urandom_range(1, 65535)), 8);
        test_random_traffic(76, 17, 16'hFFFF, 8);
        test_random_traffic(0, 0, 16'd1, 8);
        test_backpressure();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sample_packet_deframer.f @@
hdl/spd_pkg.sv
hdl/spd_front.sv
hdl/spd_queue.sv
hdl/spd_back.sv
hdl/sample_packet_deframer.sv
dv/tb_top.sv
